// ===== sv/rtbl_pkg.sv =====
`default_nettype none
package rtbl_pkg;

  // Table sizes
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned MAX_ALIASES = 256;
  localparam int unsigned ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned ALIAS_AW    = $clog2(MAX_ALIASES);
  localparam int unsigned ALIAS_CNT_W = ALIAS_AW + 1;

  // Field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned OFS_W    = 32;
  localparam int unsigned TGT_W    = 16;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // APB side
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_RES_LOAD   = 2'd0,
    KIND_ALIAS_LOAD = 2'd1,
    KIND_LOOKUP     = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_MISSING  = 2'd1,
    ST_BADRANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_RESOURCE_COUNT = 2'd0,
    REG_ALIAS_COUNT    = 2'd1,
    REG_DATA_LENGTH    = 2'd2
  } reg_idx_e;

endpackage
`default_nettype wire

// ===== sv/rtbl_req_if.sv =====
`default_nettype none
interface rtbl_req_if;
  import rtbl_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot;
  logic [ID_W-1:0]     resource_id;
  logic [OFS_W-1:0]    byte_offset;
  logic [TGT_W-1:0]    alias_target;

  modport source (
    output valid, kind, slot, resource_id, byte_offset, alias_target,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, resource_id, byte_offset, alias_target,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/rtbl_rsp_if.sv =====
`default_nettype none
interface rtbl_rsp_if;
  import rtbl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFS_W-1:0]    start_offset;
  logic [OFS_W-1:0]    length;

  modport source (
    output valid, status, start_offset, length,
    input  ready
  );
  modport sink (
    input  valid, status, start_offset, length,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/resource_table_binary_lookup_top.sv =====
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------------------
// req_i    | in  | valid/ready          | kind, slot, resource_id, byte_offset,
//          |     |                      | alias_target
// rsp_o    | out | valid/ready          | status, start_offset, length
// apb      | in  | psel/penable/pready  | paddr, pwdata, pwrite -> prdata
//
// A load is written to its table when it is accepted. A lookup makes Pr <= 10
// probes of the entry table and, if that search fails, Pa <= 9 of the alias
// table, then reads two offsets (S_OFS0, S_OFS1) and checks them (S_CHECK) up
// to the result register; each probe is one read of a table memory plus one compare in the shared comparator.
// Reset (rst_ni low, async) clears the sequencer, counts and result valid;
// table memories hold no reset value. A stalled response does not block new
// requests, but the next lookup waits at its end until the result register frees.
`default_nettype none
module resource_table_binary_lookup_top
  import rtbl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  rtbl_req_if.sink               req_i,
  rtbl_rsp_if.source             rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RPROBE = 9'b000000010,
    S_RCMP   = 9'b000000100,
    S_APROBE = 9'b000001000,
    S_ACMP   = 9'b000010000,
    S_OFS0   = 9'b000100000,
    S_OFS1   = 9'b001000000,
    S_CHECK  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [ENTRY_AW-1:0]    rc_q;
  logic [ALIAS_CNT_W-1:0] ac_q;
  logic [OFS_W-1:0]       dl_q;
  reg_idx_e               reg_idx;
  logic                   cfg_wr;

  // Search state
  logic [ENTRY_AW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [ENTRY_AW-1:0] idx_q, idx_d, mid_c, span_c;
  logic [ID_W-1:0]     key_q, key_d;
  logic [OFS_W-1:0]    s_q, s_d;
  logic [ALIAS_CNT_W-1:0] n_alias;

  // Result holding and output registers
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic [OFS_W-1:0]    res_start_q, res_start_d, res_len_q, res_len_d;
  logic                ov_q;
  logic [STATUS_W-1:0] ost_q;
  logic [OFS_W-1:0]    ostart_q, olen_q;
  logic                out_load;

  // Memories
  logic [ID_W+OFS_W-1:0]  ent_mem [MAX_ENTRIES];
  logic [ID_W+TGT_W-1:0]  ali_mem [MAX_ALIASES];
  logic [ID_W+OFS_W-1:0]  ent_rd_q;
  logic [ID_W+TGT_W-1:0]  ali_rd_q;
  logic [ENTRY_AW-1:0]    ent_raddr;

  // Shared comparator
  logic [ID_W-1:0]     cmp_v;
  logic                cmp_eq, cmp_lt;
  logic [ENTRY_AW-1:0] nlo, nhi;
  logic [TGT_W-1:0]    tgt;
  logic [OFS_W-1:0]    e_ofs;

  logic req_acc;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
      ac_q <= '0;
      dl_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RESOURCE_COUNT: rc_q <= pwdata[ENTRY_AW-1:0];
        REG_ALIAS_COUNT:    ac_q <= pwdata[ALIAS_CNT_W-1:0];
        REG_DATA_LENGTH:    dl_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RESOURCE_COUNT: prdata = APB_DW'(rc_q);
      REG_ALIAS_COUNT:    prdata = APB_DW'(ac_q);
      REG_DATA_LENGTH:    prdata = dl_q;
      default:            prdata = '0;
    endcase
  end

  // ---------------- Request side ----------------
  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // Table writes and registered reads
  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.kind == KIND_RES_LOAD)) begin
      ent_mem[req_i.slot[ENTRY_AW-1:0]] <= {req_i.resource_id, req_i.byte_offset};
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.kind == KIND_ALIAS_LOAD)
        && (req_i.slot < SLOT_W'(MAX_ALIASES))) begin
      ali_mem[req_i.slot[ALIAS_AW-1:0]] <= {req_i.resource_id, req_i.alias_target};
    end
    ali_rd_q <= ali_mem[mid_c[ALIAS_AW-1:0]];
  end

  // Midpoint of [lo, hi): lo + (hi - 1 - lo) / 2
  assign span_c = hi_q - ENTRY_AW'(1) - lo_q;
  assign mid_c  = lo_q + (span_c >> 1);

  always_comb begin
    unique case (state_q)
      S_OFS0:  ent_raddr = idx_q;
      S_OFS1:  ent_raddr = idx_q + ENTRY_AW'(1);
      default: ent_raddr = mid_c;
    endcase
  end

  assign n_alias = (ac_q > ALIAS_CNT_W'(MAX_ALIASES)) ? ALIAS_CNT_W'(MAX_ALIASES) : ac_q;

  // Shared compare and bound update
  assign cmp_v  = state_q[4] ? ali_rd_q[ID_W+TGT_W-1:TGT_W] : ent_rd_q[ID_W+OFS_W-1:OFS_W];
  assign cmp_eq = (cmp_v == key_q);
  assign cmp_lt = (cmp_v < key_q);
  assign nlo    = cmp_lt ? (mid_q + ENTRY_AW'(1)) : lo_q;
  assign nhi    = cmp_lt ? hi_q : mid_q;
  assign tgt    = ali_rd_q[TGT_W-1:0];
  assign e_ofs  = ent_rd_q[OFS_W-1:0];

  assign out_load = (state_q == S_DONE) && (!ov_q || rsp_o.ready);

  // ---------------- Sequencer ----------------
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    key_d       = key_q;
    s_d         = s_q;
    res_st_d    = res_st_q;
    res_start_d = res_start_q;
    res_len_d   = res_len_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc && (req_i.kind == KIND_LOOKUP)) begin
          key_d       = req_i.resource_id;
          lo_d        = '0;
          hi_d        = rc_q;
          res_st_d    = ST_MISSING;
          res_start_d = '0;
          res_len_d   = '0;
          state_d     = (rc_q == '0) ? S_DONE : S_RPROBE;
        end
      end
      S_RPROBE: begin
        mid_d   = mid_c;
        state_d = S_RCMP;
      end
      S_RCMP: begin
        if (cmp_eq) begin
          idx_d   = mid_q;
          state_d = S_OFS0;
        end else if (nlo < nhi) begin
          lo_d    = nlo;
          hi_d    = nhi;
          state_d = S_RPROBE;
        end else begin
          // entry search failed, fall back to the alias table
          lo_d    = '0;
          hi_d    = ENTRY_AW'(n_alias);
          state_d = (n_alias == '0) ? S_DONE : S_APROBE;
        end
      end
      S_APROBE: begin
        mid_d   = mid_c;
        state_d = S_ACMP;
      end
      S_ACMP: begin
        if (cmp_eq) begin
          // target past the table end answers not found
          if (tgt < TGT_W'(rc_q)) begin
            idx_d   = tgt[ENTRY_AW-1:0];
            state_d = S_OFS0;
          end else begin
            state_d = S_DONE;
          end
        end else if (nlo < nhi) begin
          lo_d    = nlo;
          hi_d    = nhi;
          state_d = S_APROBE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_OFS0: state_d = S_OFS1;
      S_OFS1: begin
        s_d     = e_ofs;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((e_ofs < s_q) || (e_ofs > dl_q)) begin
          res_st_d = ST_BADRANGE;
        end else begin
          res_st_d    = ST_FOUND;
          res_start_d = s_q;
          res_len_d   = e_ofs - s_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    idx_q       <= idx_d;
    key_q       <= key_d;
    s_q         <= s_d;
    res_st_q    <= res_st_d;
    res_start_q <= res_start_d;
    res_len_q   <= res_len_d;
  end

  // ---------------- Response register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (rsp_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ost_q    <= res_st_q;
      ostart_q <= res_start_q;
      olen_q   <= res_len_q;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.start_offset = ostart_q;
  assign rsp_o.length       = olen_q;

endmodule
`default_nettype wire

// ===== sv/rtbl_checker.sv =====
`default_nettype none
module rtbl_checker
  import rtbl_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid_i,
  input wire logic                req_ready_i,
  input wire logic [KIND_W-1:0]   req_kind_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] rsp_status_i,
  input wire logic [OFS_W-1:0]    rsp_start_i,
  input wire logic [OFS_W-1:0]    rsp_length_i
);

  logic lookup_acc;
  assign lookup_acc = req_valid_i && req_ready_i && (req_kind_i == KIND_LOOKUP);

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_start_i) && $stable(rsp_length_i))
    else $error("response changed while stalled");

  // A lookup blocks further requests while it searches
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> !req_ready_i)
    else $error("request taken during a lookup");

  // No result can appear in the cycle right after a lookup is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_acc |=> !$rose(rsp_valid_i))
    else $error("lookup answered too early");

  // Only defined status codes leave the block
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_FOUND) || (rsp_status_i == ST_MISSING)
      || (rsp_status_i == ST_BADRANGE))
    else $error("undefined status code");

  // Misses and bad ranges carry zero offset and length
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_FOUND) |-> (rsp_start_i == '0) && (rsp_length_i == '0))
    else $error("non-found result carries data");

endmodule

bind resource_table_binary_lookup_top rtbl_checker u_rtbl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_kind_i   (req_i.kind),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_start_i  (rsp_o.start_offset),
  .rsp_length_i (rsp_o.length)
);
`default_nettype wire
